// ===== rtl/rsbb_pkg.sv =====
// rsbb_pkg: shared widths, constants, codes and word types for the rotated shape
// bounding box unit. No dependencies; used by rtl/rotated_shape_bounding_box_unit.sv.
package rsbb_pkg;

  // coordinate width of the running box, default for the top level parameter
  localparam int COORD_WIDTH_DEF = 32;

  // fixed field widths
  localparam int PT_W   = 32;   // point coordinates, Q16.16 signed
  localparam int RAD_W  = 31;   // radius, Q15.16 unsigned
  localparam int HALF_W = 31;   // output half-width
  localparam int QUAT_W = 16;   // quaternion components, Q2.14 signed

  // rotation matrix arithmetic
  localparam int QP_W     = 2 * QUAT_W;  // product of two components, Q.28
  localparam int MQ_W     = QP_W + 4;    // matrix entry before rounding, Q.28
  localparam int FRAC_SH  = 14;          // Q.28 -> Q.14 and Q.30 -> Q.16
  localparam int MAT_W    = 20;          // rounded matrix entry, Q.14
  localparam int PROD_W   = MAT_W + PT_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int ROT_W    = ACC_W - FRAC_SH;

  localparam logic signed [MQ_W-1:0]  MQ_ONE   = MQ_W'(268435456);  // 1.0 in Q.28
  localparam logic signed [MQ_W-1:0]  MQ_HALF  = MQ_W'(8192);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(8192);

  // register file
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_W = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_X = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_Y = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_Z = 2'd3;

  localparam logic signed [QUAT_W-1:0] QUAT_W_RST = 16'sd16384;  // 1.0 in Q2.14

  typedef enum logic [1:0] {
    MODE_HULL    = 2'd0,
    MODE_SPHERE  = 2'd1,
    MODE_CAPSULE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]             mode;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
    logic [RAD_W-1:0]       radius;
    logic                   last_vertex;
  } item_t;

  typedef struct packed {
    logic signed [PT_W-1:0] center_x;
    logic signed [PT_W-1:0] center_y;
    logic signed [PT_W-1:0] center_z;
    logic [HALF_W-1:0]      half_x;
    logic [HALF_W-1:0]      half_y;
    logic [HALF_W-1:0]      half_z;
  } box_t;

  function automatic logic signed [MQ_W-1:0] sext_qp(input logic signed [QP_W-1:0] v);
    return {{(MQ_W - QP_W){v[QP_W-1]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] sext_prod(input logic signed [PROD_W-1:0] v);
    return {{(ACC_W - PROD_W){v[PROD_W-1]}}, v};
  endfunction

endpackage

// ===== rtl/rotated_shape_bounding_box_unit.sv =====
// rotated_shape_bounding_box_unit: local axis-aligned box of a hull, sphere or capsule
// under a quaternion orientation. Depends on rtl/rsbb_pkg.sv.
//
// an accepted word reaches box_valid via the input, product, rotate and output regs
// throughput: one word per cycle; every stage advances together whenever the
//   output register is empty or being drained, so the output handshake sets the pace
// reset (rst, synchronous, active high): pipeline valids and box_valid clear, the
//   quaternion returns to identity and the running min/max return to their extremes
module rotated_shape_bounding_box_unit #(
  parameter int COORD_WIDTH = rsbb_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsbb_pkg::PADDR_W-1:0]   paddr,
  input  logic [rsbb_pkg::PDATA_W-1:0]   pwdata,
  output logic [rsbb_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  // vertex / shape words in
  input  logic                           item_valid,
  output logic                           item_ready,
  input  rsbb_pkg::item_t                item,
  // box words out
  output logic                           box_valid,
  input  logic                           box_ready,
  output rsbb_pkg::box_t                 box
);

  localparam int CW = COORD_WIDTH;

  // coordinate range of the running box
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // wide copies of the range for the rotate saturation
  localparam int SAT_W = ((CW > rsbb_pkg::ROT_W) ? CW : rsbb_pkg::ROT_W) + 1;
  localparam logic signed [SAT_W-1:0] CMAX_S = {{(SAT_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] CMIN_S = {{(SAT_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

  // width for magnitude plus radius
  localparam int H_W = ((CW > rsbb_pkg::RAD_W) ? CW : rsbb_pkg::RAD_W) + 1;
  localparam logic [H_W-1:0] CMAX_H = {{(H_W-CW+1){1'b0}}, {(CW-1){1'b1}}};

  // width for the final 32-bit output saturation
  localparam int E_W = ((CW + 1) > 33) ? (CW + 1) : 33;
  localparam logic signed [E_W-1:0] OUT_MAX_E = {{(E_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [E_W-1:0] OUT_MIN_E = {{(E_W-31){1'b1}}, {31{1'b0}}};

  // -------------------------------------------------------------------------
  // register file: four quaternion components, written on the access phase
  // -------------------------------------------------------------------------
  logic signed [rsbb_pkg::QUAT_W-1:0] qw, qx, qy, qz;
  logic [rsbb_pkg::REG_IDX_W-1:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rsbb_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      qw <= rsbb_pkg::QUAT_W_RST;
      qx <= '0;
      qy <= '0;
      qz <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        rsbb_pkg::REG_QUAT_W: qw <= pwdata[rsbb_pkg::QUAT_W-1:0];
        rsbb_pkg::REG_QUAT_X: qx <= pwdata[rsbb_pkg::QUAT_W-1:0];
        rsbb_pkg::REG_QUAT_Y: qy <= pwdata[rsbb_pkg::QUAT_W-1:0];
        rsbb_pkg::REG_QUAT_Z: qz <= pwdata[rsbb_pkg::QUAT_W-1:0];
        default: ;
      endcase
    end
  end

  // reads return the component sign-extended to the bus
  always_comb begin
    case (reg_idx)
      rsbb_pkg::REG_QUAT_W: prdata = {{(rsbb_pkg::PDATA_W-rsbb_pkg::QUAT_W){qw[15]}}, qw};
      rsbb_pkg::REG_QUAT_X: prdata = {{(rsbb_pkg::PDATA_W-rsbb_pkg::QUAT_W){qx[15]}}, qx};
      rsbb_pkg::REG_QUAT_Y: prdata = {{(rsbb_pkg::PDATA_W-rsbb_pkg::QUAT_W){qy[15]}}, qy};
      rsbb_pkg::REG_QUAT_Z: prdata = {{(rsbb_pkg::PDATA_W-rsbb_pkg::QUAT_W){qz[15]}}, qz};
      default:              prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // rotation matrix: rebuilt from the quaternion every cycle and registered,
  // so a write reaches it through the quaternion and matrix registers before
  // any new word reaches the product stage
  // -------------------------------------------------------------------------
  logic signed [rsbb_pkg::QP_W-1:0]  p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
  logic signed [rsbb_pkg::MQ_W-1:0]  mq     [3][3];
  logic signed [rsbb_pkg::MQ_W-1:0]  mq_rnd [3][3];
  logic signed [rsbb_pkg::MAT_W-1:0] mat_next [3][3];
  logic signed [rsbb_pkg::MAT_W-1:0] mat      [3][3];

  assign p_xx = qx * qx;
  assign p_yy = qy * qy;
  assign p_zz = qz * qz;
  assign p_xy = qx * qy;
  assign p_xz = qx * qz;
  assign p_yz = qy * qz;
  assign p_wx = qw * qx;
  assign p_wy = qw * qy;
  assign p_wz = qw * qz;

  always_comb begin
    // entries in Q.28, exact
    mq[0][0] = rsbb_pkg::MQ_ONE
             - ((rsbb_pkg::sext_qp(p_yy) + rsbb_pkg::sext_qp(p_zz)) <<< 1);
    mq[0][1] = (rsbb_pkg::sext_qp(p_xy) - rsbb_pkg::sext_qp(p_wz)) <<< 1;
    mq[0][2] = (rsbb_pkg::sext_qp(p_xz) + rsbb_pkg::sext_qp(p_wy)) <<< 1;
    mq[1][0] = (rsbb_pkg::sext_qp(p_xy) + rsbb_pkg::sext_qp(p_wz)) <<< 1;
    mq[1][1] = rsbb_pkg::MQ_ONE
             - ((rsbb_pkg::sext_qp(p_xx) + rsbb_pkg::sext_qp(p_zz)) <<< 1);
    mq[1][2] = (rsbb_pkg::sext_qp(p_yz) - rsbb_pkg::sext_qp(p_wx)) <<< 1;
    mq[2][0] = (rsbb_pkg::sext_qp(p_xz) - rsbb_pkg::sext_qp(p_wy)) <<< 1;
    mq[2][1] = (rsbb_pkg::sext_qp(p_yz) + rsbb_pkg::sext_qp(p_wx)) <<< 1;
    mq[2][2] = rsbb_pkg::MQ_ONE
             - ((rsbb_pkg::sext_qp(p_xx) + rsbb_pkg::sext_qp(p_yy)) <<< 1);
    // round half up into Q.14
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mq_rnd[i][j]   = mq[i][j] + rsbb_pkg::MQ_HALF;
        mat_next[i][j] = mq_rnd[i][j][rsbb_pkg::FRAC_SH+rsbb_pkg::MAT_W-1:rsbb_pkg::FRAC_SH];
      end
    end
  end

  always_ff @(posedge clk) begin
    mat <= mat_next;
  end

  // -------------------------------------------------------------------------
  // pipeline control: all stages move together when the output register
  // is free or being taken this cycle
  // -------------------------------------------------------------------------
  logic en;
  assign en         = !box_valid || box_ready;
  assign item_ready = en && !rst;

  // stage 1: input register
  logic            s1_valid;
  rsbb_pkg::item_t s1_item;
  logic signed [rsbb_pkg::PT_W-1:0] s1_pt [3];

  assign s1_pt[0] = s1_item.point_x;
  assign s1_pt[1] = s1_item.point_y;
  assign s1_pt[2] = s1_item.point_z;

  // stage 2: matrix times point, nine products
  logic                               s2_valid;
  logic [1:0]                         s2_mode;
  logic                               s2_last;
  logic [rsbb_pkg::RAD_W-1:0]         s2_radius;
  logic signed [rsbb_pkg::PROD_W-1:0] prod_next [3][3];
  logic signed [rsbb_pkg::PROD_W-1:0] prod      [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_next[i][j] = mat[i][j] * s1_pt[j];
      end
    end
  end

  // stage 3: row sums, rounded to Q16.16 and clamped to the coordinate range
  logic                              s3_valid;
  logic [1:0]                        s3_mode;
  logic                              s3_last;
  logic [rsbb_pkg::RAD_W-1:0]        s3_radius;
  logic signed [rsbb_pkg::ACC_W-1:0] acc      [3];
  logic signed [rsbb_pkg::ROT_W-1:0] rot_raw  [3];
  logic signed [SAT_W-1:0]           rot_wide [3];
  logic signed [CW-1:0]              rot_next [3];
  logic signed [CW-1:0]              s3_rot   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = rsbb_pkg::sext_prod(prod[i][0]) + rsbb_pkg::sext_prod(prod[i][1])
             + rsbb_pkg::sext_prod(prod[i][2]) + rsbb_pkg::ACC_HALF;
      rot_raw[i]  = acc[i][rsbb_pkg::ACC_W-1:rsbb_pkg::FRAC_SH];
      rot_wide[i] = {{(SAT_W-rsbb_pkg::ROT_W){rot_raw[i][rsbb_pkg::ROT_W-1]}}, rot_raw[i]};
      if (rot_wide[i] > CMAX_S) begin
        rot_next[i] = CMAX;
      end else if (rot_wide[i] < CMIN_S) begin
        rot_next[i] = CMIN;
      end else begin
        rot_next[i] = rot_wide[i][CW-1:0];
      end
    end
  end

  // -------------------------------------------------------------------------
  // stage 3 logic: running min/max for hulls, radius-based half-widths for
  // spheres and capsules, then center/half and the 32-bit output clamp
  // -------------------------------------------------------------------------
  logic signed [CW-1:0] run_min [3];
  logic signed [CW-1:0] run_max [3];
  logic signed [CW-1:0] lo_n    [3];
  logic signed [CW-1:0] hi_n    [3];
  logic signed [CW:0]   diff    [3];
  logic [CW-1:0]        half_h  [3];
  logic signed [CW:0]   ctr_h   [3];
  logic [CW-1:0]        mag     [3];
  logic [H_W-1:0]       cap_sum [3];
  logic [CW-1:0]        cap_h   [3];
  logic [H_W-1:0]       rad_h;
  logic [CW-1:0]        sph_h;
  logic [CW-1:0]        half_sel [3];
  logic signed [CW:0]   ctr_sel  [3];
  logic signed [E_W-1:0] ctr_e   [3];
  logic signed [E_W-1:0] half_e  [3];
  logic signed [rsbb_pkg::PT_W-1:0] center_o [3];
  logic [rsbb_pkg::HALF_W-1:0]      half_o   [3];
  logic            s3_emit;
  rsbb_pkg::box_t  box_next;

  // sphere: radius clamped to the coordinate range, same on every axis
  assign rad_h = {{(H_W-rsbb_pkg::RAD_W){1'b0}}, s3_radius};
  assign sph_h = (rad_h > CMAX_H) ? CMAX : rad_h[CW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // hull: fold this vertex into the running box
      lo_n[i]   = (s3_rot[i] < run_min[i]) ? s3_rot[i] : run_min[i];
      hi_n[i]   = (s3_rot[i] > run_max[i]) ? s3_rot[i] : run_max[i];
      diff[i]   = (CW+1)'(hi_n[i]) - (CW+1)'(lo_n[i]);
      half_h[i] = diff[i][CW:1];
      ctr_h[i]  = (CW+1)'(lo_n[i]) + signed'({1'b0, half_h[i]});

      // capsule: |rotated endpoint| + radius, most negative value taken as max
      if (s3_rot[i] == CMIN) begin
        mag[i] = CMAX;
      end else if (s3_rot[i][CW-1]) begin
        mag[i] = -s3_rot[i];
      end else begin
        mag[i] = s3_rot[i];
      end
      cap_sum[i] = {{(H_W-CW){1'b0}}, mag[i]} + rad_h;
      cap_h[i]   = (cap_sum[i] > CMAX_H) ? CMAX : cap_sum[i][CW-1:0];

      case (s3_mode)
        rsbb_pkg::MODE_HULL: begin
          half_sel[i] = half_h[i];
          ctr_sel[i]  = ctr_h[i];
        end
        rsbb_pkg::MODE_SPHERE: begin
          half_sel[i] = sph_h;
          ctr_sel[i]  = '0;
        end
        rsbb_pkg::MODE_CAPSULE: begin
          half_sel[i] = cap_h[i];
          ctr_sel[i]  = '0;
        end
        default: begin
          half_sel[i] = half_h[i];
          ctr_sel[i]  = ctr_h[i];
        end
      endcase

      // clamp to the output field ranges
      ctr_e[i]  = E_W'(ctr_sel[i]);
      half_e[i] = signed'({{(E_W-CW){1'b0}}, half_sel[i]});
      if (ctr_e[i] > OUT_MAX_E) begin
        center_o[i] = OUT_MAX_E[rsbb_pkg::PT_W-1:0];
      end else if (ctr_e[i] < OUT_MIN_E) begin
        center_o[i] = OUT_MIN_E[rsbb_pkg::PT_W-1:0];
      end else begin
        center_o[i] = ctr_e[i][rsbb_pkg::PT_W-1:0];
      end
      half_o[i] = (half_e[i] > OUT_MAX_E) ? OUT_MAX_E[rsbb_pkg::HALF_W-1:0]
                                          : half_e[i][rsbb_pkg::HALF_W-1:0];
    end
  end

  // a word leaves for the last hull vertex, any sphere and any capsule
  assign s3_emit = s3_valid && (((s3_mode == rsbb_pkg::MODE_HULL) && s3_last)
                             || (s3_mode == rsbb_pkg::MODE_SPHERE)
                             || (s3_mode == rsbb_pkg::MODE_CAPSULE));

  always_comb begin
    box_next.center_x = center_o[0];
    box_next.center_y = center_o[1];
    box_next.center_z = center_o[2];
    box_next.half_x   = half_o[0];
    box_next.half_y   = half_o[1];
    box_next.half_z   = half_o[2];
  end

  // -------------------------------------------------------------------------
  // pipeline registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      box_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= item_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      box_valid <= s3_emit;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      s1_item   <= item;
      prod      <= prod_next;
      s2_mode   <= s1_item.mode;
      s2_last   <= s1_item.last_vertex;
      s2_radius <= s1_item.radius;
      s3_rot    <= rot_next;
      s3_mode   <= s2_mode;
      s3_last   <= s2_last;
      s3_radius <= s2_radius;
      box       <= box_next;
    end
  end

  // running box: updated by hull vertices, cleared after every result,
  // untouched by the unused mode code
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        run_min[i] <= CMAX;
        run_max[i] <= CMIN;
      end
    end else if (en && s3_valid) begin
      case (s3_mode)
        rsbb_pkg::MODE_HULL: begin
          for (int i = 0; i < 3; i++) begin
            run_min[i] <= s3_last ? CMAX : lo_n[i];
            run_max[i] <= s3_last ? CMIN : hi_n[i];
          end
        end
        rsbb_pkg::MODE_SPHERE, rsbb_pkg::MODE_CAPSULE: begin
          for (int i = 0; i < 3; i++) begin
            run_min[i] <= CMAX;
            run_max[i] <= CMIN;
          end
        end
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_box_rise_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(box_valid) |-> $past(s3_emit))
    else $error("box_valid rose without an emitting word in the last stage");

  a_hull_mid_silent: assert property (@(posedge clk) disable iff (rst)
    (en && s3_valid && (s3_mode == rsbb_pkg::MODE_HULL) && !s3_last) |=> !box_valid)
    else $error("a non-final hull vertex produced a box");

  a_round_center_zero: assert property (@(posedge clk) disable iff (rst)
    (en && s3_valid && ((s3_mode == rsbb_pkg::MODE_SPHERE)
                     || (s3_mode == rsbb_pkg::MODE_CAPSULE)))
    |=> (box_valid && (box.center_x == '0) && (box.center_y == '0) && (box.center_z == '0)))
    else $error("sphere or capsule box has a nonzero center");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (en && s3_emit) |=> ((run_min[0] == CMAX) && (run_max[0] == CMIN)
                      && (run_min[1] == CMAX) && (run_max[1] == CMIN)
                      && (run_min[2] == CMAX) && (run_max[2] == CMIN)))
    else $error("running box not cleared after a result");

endmodule

// ===== tb/sv/tb_rotated_shape_bounding_box_unit.sv =====
// testbench for the rotated shape bounding box unit: directed words then random hull,
// sphere and capsule streams under several orientations, checked against a built-in predictor
// depends on rtl/rsbb_pkg.sv and rtl/rotated_shape_bounding_box_unit.sv
module tb_rotated_shape_bounding_box_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // coordinate extremes, Q16.16
  localparam logic signed [rsbb_pkg::PT_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [rsbb_pkg::PT_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic [rsbb_pkg::RAD_W-1:0]       R_MAX = 31'h7FFF_FFFF;
  localparam longint                 BOX_MAX = 64'sd2147483647;
  localparam longint                 BOX_MIN = -BOX_MAX - 1;
  localparam longint                 ROT_ONE = 64'sd268435456;  // 1.0 in Q.28
  localparam longint                 RND_HALF = 64'sd8192;

  // shape code the block must drop without a trace
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 1150;
  localparam int NUM_PHASES   = 7;
  localparam int DRAIN_CYCLES = 8;       // comfortably past the three-stage pipeline
  localparam int SQUEEZE_LEN  = 300;     // long receiver hold-off, fills the pipeline

  typedef longint vec3_t [3];

  typedef struct {
    rsbb_pkg::item_t w;
    bit              typed;   // expected box written out by hand
    rsbb_pkg::box_t  b;
  } dir_row_t;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [rsbb_pkg::PADDR_W-1:0]  paddr;
  logic [rsbb_pkg::PDATA_W-1:0]  pwdata;
  logic [rsbb_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;
  logic                          item_valid;
  logic                          item_ready;
  rsbb_pkg::item_t               item;
  logic                          box_valid;
  logic                          box_ready;
  rsbb_pkg::box_t                box;

  // predictor state: orientation mirror and running box
  logic signed [rsbb_pkg::QUAT_W-1:0] quat [4];
  vec3_t                              run_min;
  vec3_t                              run_max;

  rsbb_pkg::box_t pending_boxes [$];
  int   errors;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   squeeze_req;

  rotated_shape_bounding_box_unit dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .box_valid  (box_valid),
    .box_ready  (box_ready),
    .box        (box)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void clear_box_acc();
    for (int i = 0; i < 3; i++) begin
      run_min[i] = BOX_MAX;
      run_max[i] = BOX_MIN;
    end
  endfunction

  // rotation matrix built exactly in Q.28, rounded to Q.14, then applied to a Q16.16 point
  function automatic void rotate_point(input vec3_t p, output vec3_t v);
    longint w, x, y, z;
    longint m [9];
    longint acc;
    w = quat[rsbb_pkg::REG_QUAT_W];
    x = quat[rsbb_pkg::REG_QUAT_X];
    y = quat[rsbb_pkg::REG_QUAT_Y];
    z = quat[rsbb_pkg::REG_QUAT_Z];
    m[0] = ROT_ONE - 2 * (y * y + z * z);
    m[1] = 2 * (x * y - w * z);
    m[2] = 2 * (x * z + w * y);
    m[3] = 2 * (x * y + w * z);
    m[4] = ROT_ONE - 2 * (x * x + z * z);
    m[5] = 2 * (y * z - w * x);
    m[6] = 2 * (x * z - w * y);
    m[7] = 2 * (y * z + w * x);
    m[8] = ROT_ONE - 2 * (x * x + y * y);
    for (int i = 0; i < 9; i++) m[i] = (m[i] + RND_HALF) >>> rsbb_pkg::FRAC_SH;
    for (int i = 0; i < 3; i++) begin
      acc = m[3*i] * p[0] + m[3*i+1] * p[1] + m[3*i+2] * p[2];
      v[i] = clamp((acc + RND_HALF) >>> rsbb_pkg::FRAC_SH, BOX_MIN, BOX_MAX);
    end
  endfunction

  function automatic rsbb_pkg::box_t box_of(vec3_t lo, vec3_t hi);
    rsbb_pkg::box_t b;
    longint         half [3];
    longint         ctr [3];
    for (int i = 0; i < 3; i++) begin
      half[i] = (hi[i] - lo[i]) >>> 1;
      ctr[i]  = clamp(lo[i] + half[i], BOX_MIN, BOX_MAX);
      half[i] = clamp(half[i], 0, BOX_MAX);
    end
    b.center_x = rsbb_pkg::PT_W'(ctr[0]);
    b.center_y = rsbb_pkg::PT_W'(ctr[1]);
    b.center_z = rsbb_pkg::PT_W'(ctr[2]);
    b.half_x   = rsbb_pkg::HALF_W'(half[0]);
    b.half_y   = rsbb_pkg::HALF_W'(half[1]);
    b.half_z   = rsbb_pkg::HALF_W'(half[2]);
    return b;
  endfunction

  // advances the running box by one word; returns 1 when the word yields a box
  function automatic bit predict_box(rsbb_pkg::item_t w, output rsbb_pkg::box_t b);
    vec3_t  p, v, lo, hi;
    longint r, a;
    p[0] = longint'(w.point_x);
    p[1] = longint'(w.point_y);
    p[2] = longint'(w.point_z);
    r    = longint'(w.radius);
    b    = '0;
    case (w.mode)
      rsbb_pkg::MODE_HULL: begin
        rotate_point(p, v);
        for (int i = 0; i < 3; i++) begin
          if (v[i] < run_min[i]) run_min[i] = v[i];
          if (v[i] > run_max[i]) run_max[i] = v[i];
        end
        if (!w.last_vertex) return 1'b0;
        b = box_of(run_min, run_max);
      end
      rsbb_pkg::MODE_SPHERE: begin
        for (int i = 0; i < 3; i++) begin
          hi[i] = clamp(r, 0, BOX_MAX);
          lo[i] = -hi[i];
        end
        b = box_of(lo, hi);
      end
      rsbb_pkg::MODE_CAPSULE: begin
        rotate_point(p, v);
        for (int i = 0; i < 3; i++) begin
          a = (v[i] < 0) ? ((v[i] == BOX_MIN) ? BOX_MAX : -v[i]) : v[i];
          a = (a > BOX_MAX - r) ? BOX_MAX : a + r;
          hi[i] = a;
          lo[i] = -a;
        end
        b = box_of(lo, hi);
      end
      default: return 1'b0;
    endcase
    // any result, hull or not, restarts the running box
    clear_box_acc();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic rsbb_pkg::item_t mk_item(logic [1:0] mode,
                                              logic signed [rsbb_pkg::PT_W-1:0] x,
                                              logic signed [rsbb_pkg::PT_W-1:0] y,
                                              logic signed [rsbb_pkg::PT_W-1:0] z,
                                              logic [rsbb_pkg::RAD_W-1:0] r, logic last);
    rsbb_pkg::item_t w;
    w.mode        = mode;
    w.point_x     = x;
    w.point_y     = y;
    w.point_z     = z;
    w.radius      = r;
    w.last_vertex = last;
    return w;
  endfunction

  function automatic rsbb_pkg::box_t mk_box(logic signed [rsbb_pkg::PT_W-1:0] cx,
                                            logic signed [rsbb_pkg::PT_W-1:0] cy,
                                            logic signed [rsbb_pkg::PT_W-1:0] cz,
                                            logic [rsbb_pkg::HALF_W-1:0] hx,
                                            logic [rsbb_pkg::HALF_W-1:0] hy,
                                            logic [rsbb_pkg::HALF_W-1:0] hz);
    rsbb_pkg::box_t b;
    b.center_x = cx;
    b.center_y = cy;
    b.center_z = cz;
    b.half_x   = hx;
    b.half_y   = hy;
    b.half_z   = hz;
    return b;
  endfunction

  // mostly small coordinates so hulls stay meaningful, with extremes and full-range noise
  function automatic logic signed [rsbb_pkg::PT_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return C_MAX;
      1:       return C_MIN;
      2, 3, 4: return rsbb_pkg::PT_W'($urandom());
      default: return rsbb_pkg::PT_W'($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
    endcase
  endfunction

  function automatic logic [rsbb_pkg::RAD_W-1:0] rand_radius();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return R_MAX;
      2, 3, 4: return rsbb_pkg::RAD_W'($urandom());
      default: return rsbb_pkg::RAD_W'($urandom_range(0, 32'h3F_FFFF));
    endcase
  endfunction

  function automatic rsbb_pkg::item_t rand_item(logic [1:0] mode, logic last);
    return mk_item(mode, rand_coord(), rand_coord(), rand_coord(), rand_radius(), last);
  endfunction

  // one APB transfer: setup cycle, access cycle; read data sampled mid access cycle
  task automatic apb_xfer(input logic wr, input logic [rsbb_pkg::REG_IDX_W-1:0] idx,
                          input logic [rsbb_pkg::PDATA_W-1:0] data,
                          output logic [rsbb_pkg::PDATA_W-1:0] rd);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= rsbb_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rd = prdata;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic readback_reg(input logic [rsbb_pkg::REG_IDX_W-1:0] idx);
    logic [rsbb_pkg::PDATA_W-1:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd[rsbb_pkg::QUAT_W-1:0] !== quat[idx]) begin
      errors++;
      $display("%0t ns: register %0d readback, expected %0d, actual %0d",
               $time, idx, quat[idx], $signed(rd[rsbb_pkg::QUAT_W-1:0]));
    end
  endtask

  // writes all four quaternion components with junk in the unused upper bits
  task automatic program_quat(input logic signed [rsbb_pkg::QUAT_W-1:0] vals [4]);
    logic [rsbb_pkg::PDATA_W-1:0]   rd;
    logic [rsbb_pkg::REG_IDX_W-1:0] idx;
    for (int i = 0; i < 4; i++) begin
      idx = rsbb_pkg::REG_IDX_W'(i);
      apb_xfer(1'b1, idx, {16'($urandom()), vals[i]}, rd);
      quat[idx] = vals[i];
      readback_reg(idx);
    end
  endtask

  // offers one word, holds it until taken, then logs what it should produce
  task automatic send_word(input rsbb_pkg::item_t w, input bit typed,
                           input rsbb_pkg::box_t typed_box);
    int             gap;
    rsbb_pkg::box_t b;
    gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    if (predict_box(w, b)) begin
      pending_boxes.push_back(typed ? typed_box : b);
    end else if (typed) begin
      pending_boxes.push_back(typed_box);
    end
  endtask

  // waits for every expected box, then lets in-flight silent words settle
  task automatic drain_boxes();
    int n;
    n = 0;
    while (pending_boxes.size() != 0 && n < 50000) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int n_words);
    int             done;
    int             len;
    int             pick;
    bit             open;
    rsbb_pkg::box_t none;
    done = 0;
    none = '0;
    while (done < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        // hull stream, sometimes left open or broken up by a stray shape
        len  = $urandom_range(1, 8);
        open = ($urandom_range(0, 99) < 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 5) begin
            case ($urandom_range(0, 2))
              0: send_word(rand_item(rsbb_pkg::MODE_SPHERE, 1'($urandom())), 1'b0, none);
              1: send_word(rand_item(rsbb_pkg::MODE_CAPSULE, 1'($urandom())), 1'b0, none);
              default: send_word(rand_item(MODE_UNUSED, 1'($urandom())), 1'b0, none);
            endcase
            done++;
          end
          send_word(rand_item(rsbb_pkg::MODE_HULL, (i == len - 1) && !open), 1'b0, none);
          done++;
        end
      end else if (pick < 92) begin
        send_word(rand_item($urandom_range(0, 1) ? rsbb_pkg::MODE_SPHERE
                                                 : rsbb_pkg::MODE_CAPSULE,
                            1'($urandom())), 1'b0, none);
        done++;
      end else begin
        // ignored shape code, not counted
        send_word(rand_item(MODE_UNUSED, 1'($urandom())), 1'b0, none);
      end
    end
    item_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // box checker: every accepted box against the oldest expectation
  // ---------------------------------------------------------------------------

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsbb_pkg::box_t want;
    if (!rst && box_valid && box_ready) begin
      if (pending_boxes.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected box, expected none, actual %p", $time, box);
      end else begin
        want = pending_boxes.pop_front();
        check_field("center_x", longint'(want.center_x), longint'(box.center_x));
        check_field("center_y", longint'(want.center_y), longint'(box.center_y));
        check_field("center_z", longint'(want.center_z), longint'(box.center_z));
        check_field("half_x", longint'(want.half_x), longint'(box.half_x));
        check_field("half_y", longint'(want.half_y), longint'(box.half_y));
        check_field("half_z", longint'(want.half_z), longint'(box.half_z));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure plus an occasional long squeeze
  // ---------------------------------------------------------------------------

  initial begin
    int hold_left;
    int squeeze_seen;
    hold_left    = 0;
    squeeze_seen = 0;
    box_ready    = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_seen != squeeze_req) begin
        squeeze_seen = squeeze_req;
        hold_left    = SQUEEZE_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        box_ready <= 1'b0;
      end else begin
        box_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    dir_row_t                           dir_rows [$];
    logic signed [rsbb_pkg::QUAT_W-1:0] qv [4];
    int                                 per_phase;

    // every block input known from time zero
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    item_valid  = 1'b0;
    item        = '0;
    errors      = 0;
    squeeze_req = 0;
    tx_idle_pct = 23;
    rx_idle_pct = 61;

    // predictor starts from the reset orientation, identity
    quat[rsbb_pkg::REG_QUAT_W] = rsbb_pkg::QUAT_W_RST;
    quat[rsbb_pkg::REG_QUAT_X] = '0;
    quat[rsbb_pkg::REG_QUAT_Y] = '0;
    quat[rsbb_pkg::REG_QUAT_Z] = '0;
    clear_box_acc();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // registers must come up at identity
    readback_reg(rsbb_pkg::REG_QUAT_W);
    readback_reg(rsbb_pkg::REG_QUAT_X);
    readback_reg(rsbb_pkg::REG_QUAT_Y);
    readback_reg(rsbb_pkg::REG_QUAT_Z);

    // directed words under identity; a rotated point equals the point itself
    // sphere, zero and full radius, last flag ignored
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_SPHERE, 0, 0, 0, '0, 1'b0), 1'b1,
                         mk_box(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_SPHERE, C_MIN, C_MAX, C_MIN, R_MAX, 1'b0),
                         1'b1, mk_box(0, 0, 0, R_MAX, R_MAX, R_MAX)});
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_SPHERE, 5, 6, 7, 31'h1_0000, 1'b1), 1'b1,
                         mk_box(0, 0, 0, 31'h1_0000, 31'h1_0000, 31'h1_0000)});
    // single-vertex hulls at both corners, then the widest possible hull
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_HULL, C_MAX, C_MAX, C_MAX, R_MAX, 1'b1), 1'b1,
                         mk_box(C_MAX, C_MAX, C_MAX, 0, 0, 0)});
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_HULL, C_MIN, C_MIN, C_MIN, '0, 1'b1), 1'b1,
                         mk_box(C_MIN, C_MIN, C_MIN, 0, 0, 0)});
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_HULL, C_MIN, C_MIN, C_MIN, '0, 1'b0), 1'b0,
                         '0});
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_HULL, C_MAX, C_MAX, C_MAX, '0, 1'b1), 1'b1,
                         mk_box(-1, -1, -1, R_MAX, R_MAX, R_MAX)});
    // capsule at full size on every axis, then an ordinary one and an empty one
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_CAPSULE, C_MIN, 0, C_MAX, R_MAX, 1'b0), 1'b1,
                         mk_box(0, 0, 0, R_MAX, R_MAX, R_MAX)});
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_CAPSULE, 32'sh1_0000, -32'sh2_0000, 0,
                                 31'h8000, 1'b1),
                         1'b1, mk_box(0, 0, 0, 31'h1_8000, 31'h2_8000, 31'h8000)});
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_CAPSULE, 0, 0, 0, '0, 1'b0), 1'b1,
                         mk_box(0, 0, 0, 0, 0, 0)});
    // unused shape code with everything set: no box, no state change
    dir_rows.push_back('{mk_item(MODE_UNUSED, C_MAX, C_MIN, -1, R_MAX, 1'b1), 1'b0, '0});
    // sphere mid-hull throws away the partial hull
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_HULL, 1, 2, 3, '0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_SPHERE, 0, 0, 0, 31'd5, 1'b0), 1'b1,
                         mk_box(0, 0, 0, 5, 5, 5)});
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_HULL, -7, 8, 0, '0, 1'b1), 1'b1,
                         mk_box(-7, 8, 0, 0, 0, 0)});
    // capsule mid-hull, same story
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_HULL, 32'sh1000, 0, -32'sh1000, '0, 1'b0),
                         1'b0, '0});
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_CAPSULE, 0, 0, 0, 31'd1, 1'b0), 1'b1,
                         mk_box(0, 0, 0, 1, 1, 1)});
    // two-vertex hulls, the second with odd spans so halving floors
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_HULL, 10, 20, 30, '0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_HULL, -10, 40, 31, '0, 1'b1), 1'b1,
                         mk_box(0, 30, 30, 10, 10, 0)});
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_HULL, 0, 0, 0, R_MAX, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_item(rsbb_pkg::MODE_HULL, 1, -1, 3, R_MAX, 1'b1), 1'b1,
                         mk_box(0, -1, 1, 0, 0, 1)});

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].b);
    item_valid <= 1'b0;
    drain_boxes();

    // random phases, one orientation each; idling pattern moves through three settings
    per_phase = RANDOM_WORDS / NUM_PHASES;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin  // quarter turn about z
          qv[rsbb_pkg::REG_QUAT_W] = 16'sd11585; qv[rsbb_pkg::REG_QUAT_X] = '0;
          qv[rsbb_pkg::REG_QUAT_Y] = '0;         qv[rsbb_pkg::REG_QUAT_Z] = 16'sd11585;
        end
        1: begin  // every component at its most negative
          qv[rsbb_pkg::REG_QUAT_W] = 16'sh8000; qv[rsbb_pkg::REG_QUAT_X] = 16'sh8000;
          qv[rsbb_pkg::REG_QUAT_Y] = 16'sh8000; qv[rsbb_pkg::REG_QUAT_Z] = 16'sh8000;
        end
        2: begin  // every component at its most positive
          qv[rsbb_pkg::REG_QUAT_W] = 16'sh7FFF; qv[rsbb_pkg::REG_QUAT_X] = 16'sh7FFF;
          qv[rsbb_pkg::REG_QUAT_Y] = 16'sh7FFF; qv[rsbb_pkg::REG_QUAT_Z] = 16'sh7FFF;
        end
        3: begin  // all zero still gives the identity matrix
          qv[rsbb_pkg::REG_QUAT_W] = '0; qv[rsbb_pkg::REG_QUAT_X] = '0;
          qv[rsbb_pkg::REG_QUAT_Y] = '0; qv[rsbb_pkg::REG_QUAT_Z] = '0;
        end
        4: begin  // unit quaternion, every component of magnitude one half
          qv[rsbb_pkg::REG_QUAT_W] = 16'sd8192;  qv[rsbb_pkg::REG_QUAT_X] = 16'sd8192;
          qv[rsbb_pkg::REG_QUAT_Y] = -16'sd8192; qv[rsbb_pkg::REG_QUAT_Z] = 16'sd8192;
        end
        default: begin
          foreach (qv[i]) qv[i] = rsbb_pkg::QUAT_W'($urandom());
        end
      endcase
      program_quat(qv);

      if (ph < 3) begin
        tx_idle_pct = 23;
        rx_idle_pct = 61;
      end else if (ph < 5) begin
        tx_idle_pct = 61;
        rx_idle_pct = 23;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // long receiver stall while the sender keeps pushing
      if (ph == 1 || ph == 5) squeeze_req++;

      run_random(per_phase);
      drain_boxes();
    end

    if (pending_boxes.size() != 0) begin
      errors++;
      $display("%0t ns: boxes never delivered, expected %0d more, actual 0",
               $time, pending_boxes.size());
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rsbb_pkg.sv
rtl/rotated_shape_bounding_box_unit.sv
tb/sv/tb_rotated_shape_bounding_box_unit.sv
